### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held low.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Types and constants shared by the matrix-to-quaternion pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

    // Branch of the conversion that was used for a matrix.
    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    // Number of quotients formed per matrix.
    localparam int NUM_LANES = 3;

endpackage

### design/rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts a 3x3 rotation matrix into a quaternion by the trace and
// largest-diagonal method.
// ----------------------------------------------------------------------------
// The unit takes one matrix word per clock and gives one quaternion word per
// clock once the pipeline is full, unless the output stalls. The pipeline is
// the front stage, SQW root stages (SQW is half the root radicand width, one
// stage per root bit), DDW = DATA_WIDTH + 1 + FRAC_BITS quotient stages (one
// per quotient bit) and the output register. The square root and the three
// quotient lanes are the long parts of the pipeline. When the output word is
// held downstream, the whole pipeline holds with it and s_axis_tready goes
// low; nothing is dropped or repeated. m_axis_tuser gives the branch taken
// and whether the radicand had to be clamped for a non-rotation input.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
    input  logic [((9*DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // quat_w, quat_x, quat_y, quat_z from the lowest bit up
    output logic [((4*DATA_WIDTH+7)/8)*8-1:0]       m_axis_tdata,
    // branch_taken (2 bits), bad_radicand from the lowest bit up
    output logic [2:0]                              m_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready
);
    import rmq_pkg::*;

    localparam int SW   = ((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) + 3;
    localparam int NMW  = DATA_WIDTH + 1;
    localparam int IW   = SW - 1 + FRAC_BITS;
    localparam int SQW  = (IW + (IW % 2)) / 2;
    localparam int DNW  = SQW + 1;
    localparam int QW   = NMW + FRAC_BITS;
    localparam int EW   = ((QW > SQW) ? QW : SQW) + 1;
    localparam int SB1W = 3 + 3*NMW + 3;
    localparam int SB2W = 3 + 3 + (SQW - 1);
    localparam int OTW  = ((4*DATA_WIDTH+7)/8)*8;
    localparam logic [EW-1:0] MAG_MAX = {{(EW-DATA_WIDTH+1){1'b0}}, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [EW-1:0] MAG_MIN = MAG_MAX + EW'(1);

    logic                      en;
    logic                      f_v;
    logic [SW-2:0]             f_rad;
    logic [2:0][NMW-1:0]       f_mag;
    logic [2:0]                f_neg;
    t_branch                   f_br;
    logic                      f_bad;
    logic                      q_v;
    logic [SQW-1:0]            q_root;
    logic [SB1W-1:0]           q_sb;
    logic [2:0]                q_neg;
    logic [2:0][NMW-1:0]       q_mag;
    logic [1:0]                q_br;
    logic                      q_bad;
    logic                      d_v;
    logic [2:0][QW-1:0]        d_q;
    logic [SB2W-1:0]           d_sb;
    logic [2:0]                d_neg;
    logic [1:0]                d_br;
    logic                      d_bad;
    logic [SQW-2:0]            d_axis;
    logic [DATA_WIDTH-1:0]     sat_q [3];
    logic [DATA_WIDTH-1:0]     sat_axis;
    logic [4*DATA_WIDTH-1:0]   n_quat;
    logic                      r_out_v;
    logic [OTW-1:0]            r_tdata;
    logic [2:0]                r_tuser;

    // Saturate a sign and magnitude pair to the signed output range.
    function automatic logic [DATA_WIDTH-1:0] f_sat(input logic neg, input logic [EW-1:0] mag);
        logic [EW-1:0] tmp;
        tmp = EW'(0) - mag;
        if (!neg) begin
            return (mag > MAG_MAX) ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : mag[DATA_WIDTH-1:0];
        end
        return (mag > MAG_MIN) ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : tmp[DATA_WIDTH-1:0];
    endfunction

    // The whole pipeline moves while the output register is free or drained.
    assign en            = !r_out_v || m_axis_tready;
    assign s_axis_tready = en;

    // Branch choice, radicand and numerators.
    rmq_front #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (s_axis_tvalid),
        .i_m     (s_axis_tdata[9*DATA_WIDTH-1:0]),
        .o_v     (f_v),
        .o_rad   (f_rad),
        .o_mag   (f_mag),
        .o_neg   (f_neg),
        .o_br    (f_br),
        .o_bad   (f_bad)
    );

    // Root of the radicand scaled to the fixed-point format.
    rmq_sqrt #(
        .IW  (IW),
        .SBW (SB1W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (f_v),
        .i_rad   ({f_rad, {FRAC_BITS{1'b0}}}),
        .i_sb    ({f_neg, f_mag, f_br, f_bad}),
        .o_v     (q_v),
        .o_root  (q_root),
        .o_sb    (q_sb)
    );

    assign {q_neg, q_mag, q_br, q_bad} = q_sb;

    // Divisor is twice the root; the axis component is half the root.
    rmq_div #(
        .NMW       (NMW),
        .FRAC_BITS (FRAC_BITS),
        .DNW       (DNW),
        .SBW       (SB2W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_v     (q_v),
        .i_mag   (q_mag),
        .i_den   ({q_root, 1'b0}),
        .i_sb    ({q_neg, q_br, q_bad, q_root[SQW-1:1]}),
        .o_v     (d_v),
        .o_q     (d_q),
        .o_sb    (d_sb)
    );

    assign {d_neg, d_br, d_bad, d_axis} = d_sb;

    // Saturate and place the components by branch.
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            sat_q[k] = f_sat(d_neg[k], EW'(d_q[k]));
        end
        sat_axis = f_sat(1'b0, EW'(d_axis));
        case (t_branch'(d_br))
            BR_TRACE: n_quat = {sat_q[2], sat_q[1], sat_q[0], sat_axis};
            BR_X:     n_quat = {sat_q[2], sat_q[1], sat_axis, sat_q[0]};
            BR_Y:     n_quat = {sat_q[2], sat_axis, sat_q[1], sat_q[0]};
            BR_Z:     n_quat = {sat_axis, sat_q[2], sat_q[1], sat_q[0]};
            default:  n_quat = {sat_q[2], sat_q[1], sat_q[0], sat_axis};
        endcase
    end

    // Output register, valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= d_v;
        end
    end

    // Output register, payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tdata <= OTW'(n_quat);
            r_tuser <= {d_bad, d_br};
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tuser  = r_tuser;

endmodule

### design/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// First stage: trace, branch choice, radicand with clamp and the three
// numerators split into sign and magnitude.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_v,
    input  logic [8:0][DATA_WIDTH-1:0]          i_m,
    output logic                                o_v,
    output logic [((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1)+1:0] o_rad,
    output logic [2:0][DATA_WIDTH:0]            o_mag,
    output logic [2:0]                          o_neg,
    output rmq_pkg::t_branch                    o_br,
    output logic                                o_bad
);
    import rmq_pkg::*;

    localparam int SW  = ((DATA_WIDTH > FRAC_BITS+1) ? DATA_WIDTH : FRAC_BITS+1) + 3;
    localparam int NMW = DATA_WIDTH + 1;
    localparam logic signed [SW-1:0] ONE = {{(SW-1){1'b0}}, 1'b1} <<< FRAC_BITS;
    localparam logic signed [SW-1:0] MIN_POS = {{(SW-1){1'b0}}, 1'b1};

    logic signed [SW-1:0] a [9];
    logic signed [SW-1:0] tr;
    logic signed [SW-1:0] rad;
    logic signed [SW-1:0] n [3];
    logic signed [SW-1:0] absn [3];
    t_branch              br;
    logic                 bad;

    logic                 r_v;
    logic [SW-2:0]        r_rad;
    logic [2:0][NMW-1:0]  r_mag;
    logic [2:0]           r_neg;
    t_branch              r_br;
    logic                 r_bad;

    // Branch choice and the terms that go into the root and the quotients.
    always_comb begin
        for (int k = 0; k < 9; k++) begin
            a[k] = {{(SW-DATA_WIDTH){i_m[k][DATA_WIDTH-1]}}, i_m[k]};
        end
        tr  = a[0] + a[4] + a[8];
        bad = 1'b0;
        if (tr > 0) begin
            br   = BR_TRACE;
            rad  = tr + ONE;
            n[0] = a[7] - a[5];
            n[1] = a[2] - a[6];
            n[2] = a[3] - a[1];
        end else begin
            if (a[0] > a[4] && a[0] > a[8]) begin
                br   = BR_X;
                rad  = ONE + a[0] - a[4] - a[8];
                n[0] = a[7] - a[5];
                n[1] = a[1] + a[3];
                n[2] = a[2] + a[6];
            end else if (a[4] > a[8]) begin
                br   = BR_Y;
                rad  = ONE + a[4] - a[0] - a[8];
                n[0] = a[2] - a[6];
                n[1] = a[1] + a[3];
                n[2] = a[5] + a[7];
            end else begin
                br   = BR_Z;
                rad  = ONE + a[8] - a[0] - a[4];
                n[0] = a[3] - a[1];
                n[1] = a[2] + a[6];
                n[2] = a[5] + a[7];
            end
            // A matrix that is not a rotation can give a radicand at or below zero.
            if (rad <= 0) begin
                rad = MIN_POS;
                bad = 1'b1;
            end
        end
        for (int k = 0; k < NUM_LANES; k++) begin
            absn[k] = n[k][SW-1] ? -n[k] : n[k];
        end
    end

    // Stage register, valid bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    // Stage register, payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad <= rad[SW-2:0];
            r_br  <= br;
            r_bad <= bad;
            for (int k = 0; k < NUM_LANES; k++) begin
                r_mag[k] <= absn[k][NMW-1:0];
                r_neg[k] <= n[k][SW-1];
            end
        end
    end

    assign o_v   = r_v;
    assign o_rad = r_rad;
    assign o_mag = r_mag;
    assign o_neg = r_neg;
    assign o_br  = r_br;
    assign o_bad = r_bad;

endmodule

### design/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with a
// side word that travels alongside.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int IW  = 32,
    parameter int SBW = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_v,
    input  logic [IW-1:0]               i_rad,
    input  logic [SBW-1:0]              i_sb,
    output logic                        o_v,
    output logic [(IW+(IW%2))/2-1:0]    o_root,
    output logic [SBW-1:0]              o_sb
);
    localparam int NW  = IW + (IW % 2);
    localparam int SQW = NW / 2;
    localparam int RMW = SQW + 2;

    logic [NW-1:0]  s_x   [SQW+1];
    logic [RMW-1:0] s_rem [SQW+1];
    logic [SQW-1:0] s_q   [SQW+1];
    logic           s_v   [SQW+1];
    logic [SBW-1:0] s_sb  [SQW+1];

    assign s_x[0]   = NW'(i_rad);
    assign s_rem[0] = '0;
    assign s_q[0]   = '0;
    assign s_v[0]   = i_v;
    assign s_sb[0]  = i_sb;

    for (genvar k = 0; k < SQW; k++) begin : g_stage
        logic [RMW-1:0] rem_in;
        logic [RMW-1:0] trial;
        logic           ge;
        logic           r_v;
        logic [NW-1:0]  r_x;
        logic [RMW-1:0] r_rem;
        logic [SQW-1:0] r_q;
        logic [SBW-1:0] r_sb;

        // Bring down two radicand bits and try the next root bit.
        always_comb begin
            rem_in = {s_rem[k][RMW-3:0], s_x[k][NW-1 -: 2]};
            trial  = {s_q[k], 2'b01};
            ge     = (rem_in >= trial);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= s_x[k] << 2;
                r_rem <= ge ? (rem_in - trial) : rem_in;
                r_q   <= {s_q[k][SQW-2:0], ge};
                r_sb  <= s_sb[k];
            end
        end

        assign s_v[k+1]   = r_v;
        assign s_x[k+1]   = r_x;
        assign s_rem[k+1] = r_rem;
        assign s_q[k+1]   = r_q;
        assign s_sb[k+1]  = r_sb;
    end

    assign o_v    = s_v[SQW];
    assign o_root = s_q[SQW];
    assign o_sb   = s_sb[SQW];

endmodule

### design/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divider with three lanes that share one divisor:
// (mag << FRAC_BITS) / den, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int NMW       = 17,
    parameter int FRAC_BITS = 14,
    parameter int DNW       = 17,
    parameter int SBW       = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_v,
    input  logic [2:0][NMW-1:0]               i_mag,
    input  logic [DNW-1:0]                    i_den,
    input  logic [SBW-1:0]                    i_sb,
    output logic                              o_v,
    output logic [2:0][NMW+FRAC_BITS-1:0]     o_q,
    output logic [SBW-1:0]                    o_sb
);
    import rmq_pkg::*;

    localparam int DDW = NMW + FRAC_BITS;

    logic [2:0][DDW-1:0] s_x   [DDW+1];
    logic [2:0][DNW-1:0] s_rem [DDW+1];
    logic [2:0][DDW-1:0] s_q   [DDW+1];
    logic [DNW-1:0]      s_den [DDW+1];
    logic                s_v   [DDW+1];
    logic [SBW-1:0]      s_sb  [DDW+1];

    // Each lane's dividend is its magnitude scaled by the fraction bits.
    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign s_x[0][l] = {i_mag[l], {FRAC_BITS{1'b0}}};
    end
    assign s_rem[0] = '0;
    assign s_q[0]   = '0;
    assign s_den[0] = i_den;
    assign s_v[0]   = i_v;
    assign s_sb[0]  = i_sb;

    for (genvar k = 0; k < DDW; k++) begin : g_stage
        logic [2:0][DNW:0]   rem_in;
        logic [2:0]          ge;
        logic [2:0][DNW-1:0] n_rem;
        logic [2:0][DDW-1:0] n_q;
        logic [2:0][DDW-1:0] n_x;
        logic                r_v;
        logic [2:0][DDW-1:0] r_x;
        logic [2:0][DNW-1:0] r_rem;
        logic [2:0][DDW-1:0] r_q;
        logic [DNW-1:0]      r_den;
        logic [SBW-1:0]      r_sb;

        // Shift in the next dividend bit and subtract where the divisor fits.
        always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
                rem_in[l] = {s_rem[k][l], s_x[k][l][DDW-1]};
                ge[l]     = (rem_in[l] >= {1'b0, s_den[k]});
                n_rem[l]  = ge[l] ? DNW'(rem_in[l] - {1'b0, s_den[k]})
                                  : rem_in[l][DNW-1:0];
                n_q[l]    = {s_q[k][l][DDW-2:0], ge[l]};
                n_x[l]    = s_x[k][l] << 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= s_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x   <= n_x;
                r_rem <= n_rem;
                r_q   <= n_q;
                r_den <= s_den[k];
                r_sb  <= s_sb[k];
            end
        end

        assign s_v[k+1]   = r_v;
        assign s_x[k+1]   = r_x;
        assign s_rem[k+1] = r_rem;
        assign s_q[k+1]   = r_q;
        assign s_den[k+1] = r_den;
        assign s_sb[k+1]  = r_sb;
    end

    assign o_v  = s_v[DDW];
    assign o_q  = s_q[DDW];
    assign o_sb = s_sb[DDW];

endmodule

### design/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker
// Port-level checks of the matrix-to-quaternion unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmq_checker #(
    parameter int DATA_WIDTH = 16
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [((4*DATA_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    input logic [2:0]                           m_axis_tuser,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready
);
    import rmq_pkg::*;

    // A held output word keeps its value.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output word changed while stalled")

    // The trace branch never clamps its radicand.
    `ASSERT_CLK(a_trace_ok, i_clk, i_rst_n, m_axis_tvalid && (m_axis_tuser[1:0] == BR_TRACE) |-> !m_axis_tuser[2], "clamp flagged on trace branch")

    // With the output register empty the unit takes a new word.
    `ASSERT_CLK(a_ready_empty, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "not ready with empty output")

    // A stall at the output holds the input side too.
    `ASSERT_CLK(a_stall_back, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "ready while output stalled")

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_rmq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);

### tb/sv/tb_rotation_matrix_to_quaternion_unit.sv
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_unit
// Self-checking bench for the matrix-to-quaternion converter. Matrix words
// come from a directed table (branch ties, extremes, unequal diagonals) and
// then from random rotations and raw noise. Each quaternion word is compared
// against a bit-exact local predictor, with random gaps on both sides and one
// long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;
    import rmq_pkg::*;

    localparam int DW = 16;
    localparam int FB = 14;
    localparam int ONE_Q = 1 << FB;
    localparam int NUM_RANDOM = 2000;
    localparam int MAX_CYCLES = 400000;

    typedef logic signed [DW-1:0] t_q;
    typedef t_q t_matrix [9];

    typedef struct {
        t_q      w, x, y, z;
        t_branch br;
        logic    bad;
    } t_quat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [143:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [63:0]  m_axis_tdata;
    logic [2:0]   m_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;

    t_quat  quat_fifo [$];
    int     mismatches = 0;
    int     words_out = 0;
    int     cycle_count = 0;
    int     branch_seen [4] = '{0, 0, 0, 0};
    int     clamp_seen = 0;
    bit     input_done = 0;
    bit     hold_off = 0;

    rotation_matrix_to_quaternion_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("rotation_matrix_to_quaternion_unit test failed");
            $finish;
        end
    end

    // Integer square root by the bit-pair method.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic t_q clip(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_q'(v);
    endfunction

    // Fixed-point quotient, truncated toward zero, then saturated.
    function automatic t_q fx_div(longint num, longint den);
        longint unsigned mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = longint'((mag << FB) / den);
        if (num < 0) q = -q;
        return clip(q);
    endfunction

    // Conversion of one matrix, trace branch or largest diagonal entry.
    function automatic t_quat convert_matrix(t_matrix m);
        t_quat  q;
        longint a [9];
        longint tr, rt, s, rad;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        tr = a[0] + a[4] + a[8];
        q.bad = 1'b0;
        if (tr > 0) begin
            rt = longint'(int_sqrt(longint'(tr + ONE_Q) << FB));
            q.br = BR_TRACE;
            q.w = clip(rt >> 1);
            q.x = fx_div(a[7] - a[5], 2 * rt);
            q.y = fx_div(a[2] - a[6], 2 * rt);
            q.z = fx_div(a[3] - a[1], 2 * rt);
        end else begin
            if (a[0] > a[4] && a[0] > a[8]) begin
                q.br = BR_X;
                rad = ONE_Q + a[0] - a[4] - a[8];
            end else if (a[4] > a[8]) begin
                q.br = BR_Y;
                rad = ONE_Q + a[4] - a[0] - a[8];
            end else begin
                q.br = BR_Z;
                rad = ONE_Q + a[8] - a[0] - a[4];
            end
            if (rad <= 0) begin
                rad = 1;
                q.bad = 1'b1;
            end
            s = 2 * longint'(int_sqrt(rad << FB));
            case (q.br)
                BR_X: begin
                    q.w = fx_div(a[7] - a[5], s);
                    q.x = clip(s >> 2);
                    q.y = fx_div(a[1] + a[3], s);
                    q.z = fx_div(a[2] + a[6], s);
                end
                BR_Y: begin
                    q.w = fx_div(a[2] - a[6], s);
                    q.x = fx_div(a[1] + a[3], s);
                    q.y = clip(s >> 2);
                    q.z = fx_div(a[5] + a[7], s);
                end
                default: begin
                    q.w = fx_div(a[3] - a[1], s);
                    q.x = fx_div(a[2] + a[6], s);
                    q.y = fx_div(a[5] + a[7], s);
                    q.z = clip(s >> 2);
                end
            endcase
        end
        return q;
    endfunction

    // Send one matrix word after a random gap; valid stays up between
    // back-to-back words.
    task automatic send_matrix(t_matrix m);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        for (int i = 0; i < 9; i++) s_axis_tdata[i*16 +: 16] <= m[i];
        s_axis_tvalid <= 1'b1;
        quat_fifo.push_back(convert_matrix(m));
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Random rotation from a normalised random integer quaternion, with noise of -4 to +4 on each entry.
    function automatic t_matrix random_rotation();
        t_matrix m;
        real w, x, y, z, n, r [9];
        w = $urandom_range(0, 2000) - 1000.0;
        x = $urandom_range(0, 2000) - 1000.0;
        y = $urandom_range(0, 2000) - 1000.0;
        z = $urandom_range(0, 2000) - 1000.0;
        n = $sqrt(w*w + x*x + y*y + z*z) + 1e-9;
        w /= n; x /= n; y /= n; z /= n;
        r = '{1 - 2*(y*y + z*z), 2*(x*y - z*w), 2*(x*z + y*w),
              2*(x*y + z*w), 1 - 2*(x*x + z*z), 2*(y*z - x*w),
              2*(x*z - y*w), 2*(y*z + x*w), 1 - 2*(x*x + y*y)};
        for (int i = 0; i < 9; i++)
            m[i] = t_q'($rtoi(r[i] * ONE_Q) + int'($urandom_range(0, 8)) - 4);
        return m;
    endfunction

    // Directed rows; an expected word is given only where it is obvious.
    typedef struct {
        t_matrix m;
        bit      has_exp;
        t_quat   exp_q;
    } t_row;

    t_row directed_rows [$];

    function automatic t_row mk_row(t_matrix m);
        t_row r;
        r.m = m;
        r.has_exp = 0;
        return r;
    endfunction

    // Stimulus.
    initial begin : stim
        t_matrix m;
        t_row    row;
        int      pick;
        // Identity: w is exactly one and nothing else.
        row = mk_row('{16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0, 16'sd16384});
        row.has_exp = 1;
        row.exp_q = '{w: 16'sd16384, x: 0, y: 0, z: 0, br: BR_TRACE, bad: 0};
        directed_rows.push_back(row);
        // Half turns about each axis.
        directed_rows.push_back(mk_row('{16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0,
                                         -16'sd16384}));
        directed_rows.push_back(mk_row('{-16'sd16384, 0, 0, 0, 16'sd16384, 0, 0, 0,
                                         -16'sd16384}));
        directed_rows.push_back(mk_row('{-16'sd16384, 0, 0, 0, -16'sd16384, 0, 0, 0,
                                         16'sd16384}));
        // Zero matrix: trace zero, ties fall through to the z branch.
        directed_rows.push_back(mk_row('{default: 0}));
        // Diagonal ties.
        directed_rows.push_back(mk_row('{-16'sd100, 0, 0, 0, -16'sd100, 0, 0, 0,
                                         -16'sd200}));
        directed_rows.push_back(mk_row('{-16'sd100, 0, 0, 0, -16'sd300, 0, 0, 0,
                                         -16'sd100}));
        // Most negative diagonal with huge off-diagonal terms.
        directed_rows.push_back(mk_row('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                         16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                                         16'sh8000}));
        // Largest positive trace.
        directed_rows.push_back(mk_row('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                         16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                                         16'sh7fff}));
        directed_rows.push_back(mk_row('{default: 16'sh7fff}));
        directed_rows.push_back(mk_row('{default: 16'sh8000}));
        directed_rows.push_back(mk_row('{default: -16'sd1}));
        // Far-apart diagonal entries, one row for each diagonal branch.
        directed_rows.push_back(mk_row('{-16'sd4000, 16'sd77, 0, 0, -16'sh7000, 0, 0, 0,
                                         16'sh7000}));
        directed_rows.push_back(mk_row('{16'sh7000, 0, 0, 16'sd5, -16'sd4000, 0, 0, 0,
                                         -16'sh7000}));
        directed_rows.push_back(mk_row('{-16'sh7000, 0, 0, 0, 16'sh7000, 0, 16'sd9, 0,
                                         -16'sd4000}));
        // The z entry is largest while x and y are tied below it.
        row = mk_row('{-16'sd8192, 0, 0, 0, -16'sd8192, 0, 0, 0, 0});
        directed_rows.push_back(row);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            send_matrix(directed_rows[i].m);
            if (directed_rows[i].has_exp) quat_fifo[$] = directed_rows[i].exp_q;
        end

        // Random part: mostly rotations, some raw noise.
        for (int n = 0; n < NUM_RANDOM; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                m = random_rotation();
            end else begin
                for (int i = 0; i < 9; i++) m[i] = t_q'($urandom);
            end
            send_matrix(m);
        end
        s_axis_tvalid <= 1'b0;
        input_done = 1;
    end

    // Receiver ready pattern: random waits, one long hold-off early on.
    initial begin : sink_ready
        int gap;
        wait (i_rst_n);
        repeat (300) begin
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
        hold_off = 1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge i_clk);
        hold_off = 0;
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
        end
    end

    // Compare each accepted quaternion word with the oldest prediction.
    always @(posedge i_clk) begin : check_quat
        t_quat e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_out++;
            if (quat_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected quaternion word %h", m_axis_tdata);
            end else begin
                e = quat_fifo.pop_front();
                branch_seen[e.br]++;
                if (e.bad) clamp_seen++;
                if (m_axis_tdata !== {e.z, e.y, e.x, e.w} ||
                    m_axis_tuser !== {e.bad, e.br}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp w=%0d x=%0d y=%0d z=%0d br=%0d bad=%0b,",
                                  " got %h tuser %b"},
                                 e.w, e.x, e.y, e.z, e.br, e.bad, m_axis_tdata, m_axis_tuser);
                end
            end
        end
    end

    // End of run.
    initial begin : finish_run
        wait (input_done);
        wait (quat_fifo.size() == 0);
        repeat (120) @(posedge i_clk);
        $display("Converted %0d matrices: trace %0d, x %0d, y %0d, z branch %0d, clamped %0d.",
                 words_out, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3],
                 clamp_seen);
        if (mismatches == 0 && quat_fifo.size() == 0) begin
            $display("rotation_matrix_to_quaternion_unit test passed");
        end else begin
            $display("rotation_matrix_to_quaternion_unit test failed");
        end
        $finish;
    end

endmodule
